@@ hdl/wtg_pkg.sv @@
// Shared types and constants for the wavetable tone generator.
// Holds table geometry, frequency set-up constants, the divider request and
// response structs and the reset waveform table. No dependencies.
package wtg_pkg;

    // Table geometry
    localparam int TABLE_SIZE = 142;
    localparam int POS_W      = $clog2(TABLE_SIZE);
    localparam int HALF_SIZE  = TABLE_SIZE / 2;
    localparam int SAMPLE_W   = 8;
    localparam int INDEX_W    = 8;
    localparam int FREQ_W     = 16;
    localparam int CMD_W      = 2;

    // Command codes carried on tuser
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREQ   = 2'd2;

    // Frequency set-up constants
    localparam int FREQ_MIN   = 550;
    localparam int FREQ_MAX   = 39060;
    localparam int FREQ_DIV   = 7812;
    localparam int FREQ_ROUND = FREQ_DIV / 2;
    localparam int FREQ_MULT  = 10 * TABLE_SIZE;
    localparam int STEP_SCALE = 100;
    localparam int SAMPLE_MAX = 255;
    localparam logic [SAMPLE_W-1:0] VALUE_BIAS = 8'h80;

    // Derived widths
    localparam int DIVIDEND_MAX = FREQ_MAX * FREQ_MULT + FREQ_ROUND;
    localparam int RAW_MAX      = DIVIDEND_MAX / FREQ_DIV;
    localparam int DIVIDEND_W   = $clog2(DIVIDEND_MAX + 1);
    localparam int RAW_W        = $clog2(RAW_MAX + 1);
    localparam int STEP_W       = $clog2(RAW_MAX / STEP_SCALE + 1);
    localparam int PER_W        = $clog2(STEP_SCALE + 1);

    // Rounded-up reciprocals for the two constant divisions. The shift spans
    // the widest dividend plus the divisor bits, so the product's top bits give
    // the exact quotient for every dividend in range.
    localparam int     RAW_SHIFT    = DIVIDEND_W + $clog2(FREQ_DIV);
    localparam longint RAW_RECIP    = ((longint'(1) << RAW_SHIFT) + FREQ_DIV - 1)
                                      / FREQ_DIV;
    localparam int     RAW_RECIP_W  = $clog2(RAW_RECIP + 1);
    localparam int     RAW_PROD_W   = DIVIDEND_W + RAW_RECIP_W;
    localparam int     STEP_SHIFT   = RAW_W + $clog2(STEP_SCALE);
    localparam longint STEP_RECIP   = ((longint'(1) << STEP_SHIFT) + STEP_SCALE - 1)
                                      / STEP_SCALE;
    localparam int     STEP_RECIP_W = $clog2(STEP_RECIP + 1);
    localparam int     WHOLE_PROD_W = RAW_W + STEP_RECIP_W;

    // Period divider: STEP_SCALE over a remainder below STEP_SCALE
    localparam int DIV_N_W   = PER_W;
    localparam int DIV_D_W   = PER_W;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    // Divider handshake
    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } t_div_rsp;

    // Frequency set-up sequencer
    typedef enum logic [2:0] {
        FS_IDLE,
        FS_MUL,
        FS_RAW,
        FS_WHOLE,
        FS_REM,
        FS_PERIOD
    } t_freq_state;

    // Reset waveform: a triangle rising to full scale at mid table
    typedef logic [SAMPLE_W-1:0] t_wave_rom [TABLE_SIZE];

    function automatic t_wave_rom build_wave_init();
        t_wave_rom rom;
        int        v;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (i < HALF_SIZE) begin
                v = (SAMPLE_MAX * i) / HALF_SIZE;
            end else begin
                v = SAMPLE_MAX - (SAMPLE_MAX * (i - HALF_SIZE)) / HALF_SIZE;
            end
            rom[i] = SAMPLE_W'(v);
        end
        return rom;
    endfunction

    localparam t_wave_rom WAVE_INIT = build_wave_init();

endpackage

@@ hdl/wtg_div.sv @@
// Restoring divider, one quotient bit per cycle, for the frequency set-up.
// Depends on wtg_pkg for widths and the request/response structs.
module wtg_div
    import wtg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_N_W-1:0]   r_quo;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_D_W-1:0]   r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;

    logic [DIV_D_W:0]     w_trial;
    logic [DIV_D_W:0]     w_diff;
    logic                 w_ge;
    logic [DIV_D_W-1:0]   n_rem;

    // Shift in the next dividend bit and try a subtraction
    always_comb begin
        w_trial = {r_rem, r_quo[DIV_N_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_rem   = w_ge ? w_diff[DIV_D_W-1:0] : w_trial[DIV_D_W-1:0];
    end

    // Count iterations; pulse done after the last quotient bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_cnt  <= DIV_CNT_W'(DIV_N_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == DIV_CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // Load operands or advance one step
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DIV_N_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;

endmodule

@@ hdl/wavetable_tone_generator_core.sv @@
// Wavetable tone generator: table memory, read position stepping and the
// frequency set-up sequencer. Depends on wtg_pkg and wtg_div.
// Sample: result valid one cycle after the transfer; table write: one cycle each.
// Set frequency: the next transfer waits for three scaling stages and, when the step has a
// fraction, the bit-serial period divide (DIV_N_W steps).
// Reset (synchronous, active low) clears position, step, count and written flags.
module wavetable_tone_generator_core
    import wtg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [31:0]         s_axis_tdata,  // table_index[7:0], entry_value[15:8], freq_dhz[31:16]
    input  logic [CMD_W-1:0]    s_axis_tuser,  // command[1:0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [SAMPLE_W-1:0] m_axis_tdata   // sample[7:0]
);

    // Input fields
    logic [INDEX_W-1:0]  w_index;
    logic [SAMPLE_W-1:0] w_value;
    logic [FREQ_W-1:0]   w_freq;
    logic                w_accept;

    assign w_index = s_axis_tdata[7:0];
    assign w_value = s_axis_tdata[15:8];
    assign w_freq  = s_axis_tdata[31:16];

    // Table storage and per-entry written flags
    logic [SAMPLE_W-1:0] r_mem [TABLE_SIZE];
    logic                r_valid [TABLE_SIZE];

    // Oscillator state
    logic [POS_W-1:0]    r_pos;
    logic [STEP_W-1:0]   r_whole;
    logic [PER_W-1:0]    r_period;
    logic [PER_W-1:0]    r_count;

    // Output stage
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_rd_mem;
    logic [SAMPLE_W-1:0] r_rd_init;
    logic                r_rd_vld;

    // Frequency set-up
    t_freq_state             r_state;
    t_freq_state             n_state;
    logic [FREQ_W-1:0]       r_fclamp;
    logic [DIVIDEND_W-1:0]   r_dividend;
    logic [RAW_W-1:0]        r_raw;
    logic [RAW_PROD_W-1:0]   w_raw_prod;
    logic [WHOLE_PROD_W-1:0] w_whole_prod;
    logic [PER_W-1:0]        w_rem;
    t_div_req                w_div_req;
    t_div_rsp                w_div_rsp;

    // Accept while the set-up is idle and the output stage can take a sample
    assign s_axis_tready = (r_state == FS_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    logic w_do_sample;
    logic w_do_write;
    logic w_do_freq;
    logic w_index_ok;

    assign w_do_sample = w_accept && (s_axis_tuser == CMD_SAMPLE);
    assign w_do_write  = w_accept && (s_axis_tuser == CMD_WRITE);
    assign w_do_freq   = w_accept && (s_axis_tuser == CMD_FREQ);
    assign w_index_ok  = ({1'b0, w_index} < (INDEX_W + 1)'(TABLE_SIZE));

    // Write the table memory
    always_ff @(posedge i_clk) begin
        if (w_do_write && w_index_ok) begin
            r_mem[w_index[POS_W-1:0]] <= w_value ^ VALUE_BIAS;
        end
    end

    // Mark written entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (w_do_write && w_index_ok) begin
            r_valid[w_index[POS_W-1:0]] <= 1'b1;
        end
    end

    // Read the entry at the current position; hold while the result waits
    always_ff @(posedge i_clk) begin
        if (w_do_sample) begin
            r_rd_mem  <= r_mem[r_pos];
            r_rd_init <= WAVE_INIT[r_pos];
            r_rd_vld  <= r_valid[r_pos];
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_do_sample) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_rd_vld ? r_rd_mem : r_rd_init;

    // Next position: whole step plus the periodic extra step, wrapped once
    logic                w_count_hit;
    logic                w_extra;
    logic [PER_W-1:0]    w_count_inc;
    logic [POS_W:0]      w_sum;
    logic [POS_W:0]      w_wrap;

    always_comb begin
        w_count_inc = r_count + 1'b1;
        w_count_hit = (r_period != '0) && (w_count_inc == r_period);
        w_extra     = w_count_hit;
        w_sum       = (POS_W + 1)'(r_pos) + (POS_W + 1)'(r_whole) + (POS_W + 1)'(w_extra);
        w_wrap      = (w_sum >= (POS_W + 1)'(TABLE_SIZE))
                      ? w_sum - (POS_W + 1)'(TABLE_SIZE) : w_sum;
    end

    // Advance position and period count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
        end else if (w_do_sample) begin
            r_pos <= w_wrap[POS_W-1:0];
            if (r_period != '0) begin
                r_count <= w_count_hit ? '0 : w_count_inc;
            end
        end else if (w_do_freq) begin
            r_count <= '0;
        end
    end

    // Clamp the requested frequency
    always_ff @(posedge i_clk) begin
        if (w_do_freq) begin
            if (w_freq < FREQ_W'(FREQ_MIN)) begin
                r_fclamp <= FREQ_W'(FREQ_MIN);
            end else if (w_freq > FREQ_W'(FREQ_MAX)) begin
                r_fclamp <= FREQ_W'(FREQ_MAX);
            end else begin
                r_fclamp <= w_freq;
            end
        end
    end

    // Reciprocal products for the raw step and the whole step
    assign w_raw_prod   = RAW_PROD_W'(r_dividend) * RAW_PROD_W'(RAW_RECIP);
    assign w_whole_prod = WHOLE_PROD_W'(r_raw) * WHOLE_PROD_W'(STEP_RECIP);

    // Fraction of the raw step; it stays below STEP_SCALE, so low bits suffice
    assign w_rem = r_raw[PER_W-1:0] - PER_W'(r_whole) * PER_W'(STEP_SCALE);

    // Scale the clamped frequency with rounding, then take the raw step
    always_ff @(posedge i_clk) begin
        if (r_state == FS_MUL) begin
            r_dividend <= DIVIDEND_W'(r_fclamp) * DIVIDEND_W'(FREQ_MULT)
                          + DIVIDEND_W'(FREQ_ROUND);
        end
        if (r_state == FS_RAW) begin
            r_raw <= w_raw_prod[RAW_SHIFT +: RAW_W];
        end
    end

    // Set-up sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Step through scaling, whole step, fraction and period divide
    always_comb begin
        n_state            = r_state;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = DIV_N_W'(STEP_SCALE);
        w_div_req.divisor  = w_rem;
        unique case (r_state)
            FS_IDLE: begin
                if (w_do_freq) begin
                    n_state = FS_MUL;
                end
            end
            FS_MUL: begin
                n_state = FS_RAW;
            end
            FS_RAW: begin
                n_state = FS_WHOLE;
            end
            FS_WHOLE: begin
                n_state = FS_REM;
            end
            FS_REM: begin
                if (w_rem == '0) begin
                    n_state = FS_IDLE;
                end else begin
                    w_div_req.start = 1'b1;
                    n_state         = FS_PERIOD;
                end
            end
            FS_PERIOD: begin
                if (w_div_rsp.done) begin
                    n_state = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    // Capture whole step and period
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_whole  <= '0;
            r_period <= '0;
        end else if (r_state == FS_WHOLE) begin
            r_whole <= w_whole_prod[STEP_SHIFT +: STEP_W];
        end else if ((r_state == FS_REM) && (w_rem == '0)) begin
            r_period <= '0;
        end else if (w_div_rsp.done && (r_state == FS_PERIOD)) begin
            r_period <= w_div_rsp.quotient[PER_W-1:0];
        end
    end

    wtg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

endmodule
